### rtl/apu_pkg.sv
// Adam parameter update: shared constants for the register map and fixed-point formats.
// Used by the top level adam_parameter_update; no dependencies.
`default_nettype none
package apu_pkg;

    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_LEARNING_RATE     = 3'd0;
    localparam logic [IDX_W-1:0] REG_BETA_FIRST        = 3'd1;
    localparam logic [IDX_W-1:0] REG_BETA_SECOND       = 3'd2;
    localparam logic [IDX_W-1:0] REG_BETA_FIRST_POWER  = 3'd3;
    localparam logic [IDX_W-1:0] REG_BETA_SECOND_POWER = 3'd4;
    localparam logic [IDX_W-1:0] REG_EPSILON           = 3'd5;
    localparam logic [IDX_W-1:0] REG_BATCH_SIZE        = 3'd6;

    localparam logic [23:0] RST_LEARNING_RATE     = 24'd16777;
    localparam logic [23:0] RST_BETA_FIRST        = 24'd15099494;
    localparam logic [23:0] RST_BETA_SECOND       = 24'd16760438;
    localparam logic [23:0] RST_BETA_FIRST_POWER  = 24'd15099494;
    localparam logic [23:0] RST_BETA_SECOND_POWER = 24'd16760438;
    localparam logic [15:0] RST_EPSILON           = 16'd1;
    localparam logic [15:0] RST_BATCH_SIZE        = 16'd1;

    localparam logic [24:0] ONE_Q24  = 25'h1000000;
    localparam logic [31:0] S32_MAX  = 32'h7FFFFFFF;
    localparam logic [31:0] S32_MIN  = 32'h80000000;

endpackage
`default_nettype wire

### rtl/apu_div.sv
// Adam parameter update: pipelined restoring divider, one quotient bit per stage.
// Flags quotients that do not fit in QW bits. Used by adam_parameter_update.
`default_nettype none
module apu_div #(
    parameter int NW = 33,
    parameter int DW = 16,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [SW-1:0] side_in,
    output logic               out_valid,
    output logic [QW-1:0]      quo,
    output logic               ovf,
    output logic [SW-1:0]      side_out
);

    logic [DW-1:0] rem_reg  [QW+1];
    logic [QW-1:0] low_reg  [QW+1];
    logic [DW-1:0] den_reg  [QW+1];
    logic [SW-1:0] side_reg [QW+1];
    logic [QW:0]   ovf_reg;
    logic [QW:0]   vld_reg;
    logic [DW:0]   trial    [QW];
    logic [DW:0]   diff     [QW];
    logic [QW-1:0] ge;
    logic [DW-1:0] top;

    assign top = DW'(num[NW-1:QW]);

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            trial[k] = {rem_reg[k], low_reg[k][QW-1]};
            diff[k]  = trial[k] - {1'b0, den_reg[k]};
            ge[k]    = (trial[k] >= {1'b0, den_reg[k]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QW-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= top;
            low_reg[0]  <= num[QW-1:0];
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
            ovf_reg[0]  <= (top >= den);
            for (int k = 0; k < QW; k++) begin
                rem_reg[k+1]  <= ge[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
                low_reg[k+1]  <= {low_reg[k][QW-2:0], ge[k]};
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quo       = low_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign side_out  = side_reg[QW];

endmodule
`default_nettype wire

### rtl/adam_parameter_update.sv
// Adam parameter update: fixed-point Adam step for one weight per transaction.
// Throughput one transaction per cycle while the output buffer does not stall the pipeline.
// Latency is set by divider pipelines (three in series: 33, 33, 34 stages) and a 25-stage sqrt.
// A two-entry output buffer decouples m_tready from the pipeline; stalls freeze all stages.
// Reset (aresetn low, synchronous) clears valid bits and loads register defaults.
// Depends on apu_pkg and apu_div.
`default_nettype none
module adam_parameter_update (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] weight, [63:32] moment_first, [95:64] moment_second, [127:96] gradient_sum
    input  wire logic [127:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] new_weight, [63:32] new_moment_first, [95:64] new_moment_second
    output logic [95:0]       m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [apu_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int SQ_STEPS = 24;
    localparam int SQ_SW    = 129;

    logic [23:0] lr_reg, b1_reg, b2_reg, b1p_reg, b2p_reg;
    logic [15:0] eps_reg, bs_reg;
    logic        cfg_wr;
    logic        en;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg  <= apu_pkg::RST_LEARNING_RATE;
            b1_reg  <= apu_pkg::RST_BETA_FIRST;
            b2_reg  <= apu_pkg::RST_BETA_SECOND;
            b1p_reg <= apu_pkg::RST_BETA_FIRST_POWER;
            b2p_reg <= apu_pkg::RST_BETA_SECOND_POWER;
            eps_reg <= apu_pkg::RST_EPSILON;
            bs_reg  <= apu_pkg::RST_BATCH_SIZE;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                apu_pkg::REG_LEARNING_RATE:     lr_reg  <= pwdata[23:0];
                apu_pkg::REG_BETA_FIRST:        b1_reg  <= pwdata[23:0];
                apu_pkg::REG_BETA_SECOND:       b2_reg  <= pwdata[23:0];
                apu_pkg::REG_BETA_FIRST_POWER:  b1p_reg <= pwdata[23:0];
                apu_pkg::REG_BETA_SECOND_POWER: b2p_reg <= pwdata[23:0];
                apu_pkg::REG_EPSILON:           eps_reg <= pwdata[15:0];
                apu_pkg::REG_BATCH_SIZE:        bs_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            apu_pkg::REG_LEARNING_RATE:     prdata = {8'd0, lr_reg};
            apu_pkg::REG_BETA_FIRST:        prdata = {8'd0, b1_reg};
            apu_pkg::REG_BETA_SECOND:       prdata = {8'd0, b2_reg};
            apu_pkg::REG_BETA_FIRST_POWER:  prdata = {8'd0, b1p_reg};
            apu_pkg::REG_BETA_SECOND_POWER: prdata = {8'd0, b2p_reg};
            apu_pkg::REG_EPSILON:           prdata = {16'd0, eps_reg};
            apu_pkg::REG_BATCH_SIZE:        prdata = {16'd0, bs_reg};
            default:                        prdata = 32'd0;
        endcase
    end

    logic [24:0] omb1, omb2, d1, d2;
    assign omb1 = apu_pkg::ONE_Q24 - {1'b0, b1_reg};
    assign omb2 = apu_pkg::ONE_Q24 - {1'b0, b2_reg};
    assign d1   = apu_pkg::ONE_Q24 - {1'b0, b1p_reg};
    assign d2   = apu_pkg::ONE_Q24 - {1'b0, b2p_reg};

    // stage 0: mean-gradient numerator
    logic [15:0] bs_eff;
    logic [31:0] g_in, gmag, numt_next;
    logic [31:0] numt_p0_reg;
    logic [15:0] bs_p0_reg;
    logic [96:0] side_p0_reg;
    logic        p0v_reg;

    assign bs_eff    = (bs_reg == 16'd0) ? 16'd1 : bs_reg;
    assign g_in      = s_tdata[127:96];
    assign gmag      = g_in[31] ? (~g_in + 32'd1) : g_in;
    assign numt_next = gmag + {17'd0, bs_eff[15:1]};

    // divide by batch size
    logic        dt_v, dt_ovf;
    logic [31:0] dt_q;
    logic [96:0] dt_side;

    apu_div #(.NW(33), .DW(16), .QW(32), .SW(97)) u_div_mean (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p0v_reg),
        .num({1'b0, numt_p0_reg}), .den(bs_p0_reg), .side_in(side_p0_reg),
        .out_valid(dt_v), .quo(dt_q), .ovf(dt_ovf), .side_out(dt_side)
    );

    // stage 1: moment products
    logic [31:0]        t_mag;
    logic signed [56:0] pa_next;
    logic [56:0]        pb_next;
    logic [63:0]        sqp_next;
    logic signed [56:0] pa_p1_reg;
    logic [56:0]        pb_p1_reg;
    logic [63:0]        sqp_p1_reg;
    logic               tneg_p1_reg;
    logic [31:0]        w_p1_reg, v_p1_reg;
    logic               p1v_reg;

    assign t_mag    = dt_ovf ? '1 : dt_q;
    assign pa_next  = $signed({1'b0, b1_reg}) * $signed(dt_side[63:32]);
    assign pb_next  = 57'(omb1) * 57'(t_mag);
    assign sqp_next = 64'(t_mag) * 64'(t_mag);

    // stage 2: first-moment sum, squared gradient
    logic signed [57:0] pbs, acc_next;
    logic [63:0]        sqr;
    logic [31:0]        sq_next;
    logic signed [57:0] acc_p2_reg;
    logic [31:0]        sq_p2_reg, w_p2_reg, v_p2_reg;
    logic               p2v_reg;

    assign pbs      = $signed({1'b0, pb_p1_reg});
    assign acc_next = $signed({pa_p1_reg[56], pa_p1_reg}) + (tneg_p1_reg ? -pbs : pbs);
    assign sqr      = sqp_p1_reg + 64'd32768;
    assign sq_next  = (sqr[63:48] != 16'd0) ? '1 : sqr[47:16];

    // stage 3: first-moment rounding, second-moment products
    logic [57:0] accmag, accrnd;
    logic [33:0] mq;
    logic [31:0] mnew_next;
    logic [55:0] pv1_next;
    logic [56:0] pv2_next;
    logic [31:0] mnew_p3_reg, w_p3_reg;
    logic [55:0] pv1_p3_reg;
    logic [56:0] pv2_p3_reg;
    logic        p3v_reg;

    assign accmag   = acc_p2_reg[57] ? (~acc_p2_reg + 58'd1) : acc_p2_reg;
    assign accrnd   = accmag + 58'h800000;
    assign mq       = accrnd[57:24];
    assign pv1_next = 56'(b2_reg) * 56'(v_p2_reg);
    assign pv2_next = 57'(omb2) * 57'(sq_p2_reg);

    always_comb begin
        if (!acc_p2_reg[57]) begin
            mnew_next = (mq > 34'(apu_pkg::S32_MAX)) ? apu_pkg::S32_MAX : mq[31:0];
        end else begin
            mnew_next = (mq > 34'(apu_pkg::S32_MIN)) ? apu_pkg::S32_MIN
                                                     : (~mq[31:0] + 32'd1);
        end
    end

    // stage 4: second-moment rounding, correction numerators
    logic [56:0] vs;
    logic [31:0] vnew_next, mmag_next;
    logic [31:0] mnew_p4_reg, mmag_p4_reg, vnew_p4_reg, w_p4_reg;
    logic        p4v_reg;

    assign vs        = 57'(pv1_p3_reg) + pv2_p3_reg + 57'h800000;
    assign vnew_next = vs[56] ? '1 : vs[55:24];
    assign mmag_next = mnew_p3_reg[31] ? (~mnew_p3_reg + 32'd1) : mnew_p3_reg;

    // bias correction dividers
    logic        dm_v, dm_ovf, dv_v, dv_ovf;
    logic [31:0] dm_q, dv_q, dv_side;
    logic [63:0] dm_side;

    apu_div #(.NW(56), .DW(25), .QW(32), .SW(64)) u_div_mhat (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p4v_reg),
        .num({mmag_p4_reg, d1[24:1]}), .den(d1), .side_in({mnew_p4_reg, w_p4_reg}),
        .out_valid(dm_v), .quo(dm_q), .ovf(dm_ovf), .side_out(dm_side)
    );

    apu_div #(.NW(56), .DW(25), .QW(32), .SW(32)) u_div_vhat (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p4v_reg),
        .num({vnew_p4_reg, d2[24:1]}), .den(d2), .side_in(vnew_p4_reg),
        .out_valid(dv_v), .quo(dv_q), .ovf(dv_ovf), .side_out(dv_side)
    );

    logic        mneg;
    logic [31:0] mlim, mhat, vhat;
    logic        mhat_neg;

    assign mneg     = dm_side[63];
    assign mlim     = mneg ? apu_pkg::S32_MIN : apu_pkg::S32_MAX;
    assign mhat     = (dm_ovf || (dm_q > mlim)) ? mlim : dm_q;
    assign mhat_neg = mneg && (dm_ovf || (dm_q != 32'd0));
    assign vhat     = dv_ovf ? '1 : dv_q;

    // square root pipeline, two radicand bits per stage
    logic [47:0]      sq_rad_reg  [SQ_STEPS+1];
    logic [25:0]      sq_rem_reg  [SQ_STEPS+1];
    logic [23:0]      sq_root_reg [SQ_STEPS+1];
    logic [SQ_SW-1:0] sq_side_reg [SQ_STEPS+1];
    logic [SQ_STEPS:0] sq_vld_reg;
    logic [27:0]      sq_trem [SQ_STEPS];
    logic [27:0]      sq_try  [SQ_STEPS];
    logic [SQ_STEPS-1:0] sq_ge;

    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            sq_trem[k] = {sq_rem_reg[k], sq_rad_reg[k][47:46]};
            sq_try[k]  = {2'b00, sq_root_reg[k], 2'b01};
            sq_ge[k]   = (sq_trem[k] >= sq_try[k]);
        end
    end

    // stage 7: denominator and step product
    logic [23:0] root;
    logic [24:0] den_c, den_next;
    logic [55:0] prod_next;
    logic [24:0] den_p7_reg;
    logic [55:0] prod_p7_reg;
    logic [96:0] side_p7_reg;
    logic        p7v_reg;

    assign root      = sq_root_reg[SQ_STEPS];
    assign den_c     = {1'b0, root} + 25'(eps_reg);
    assign den_next  = (den_c == 25'd0) ? 25'd1 : den_c;
    assign prod_next = 56'(lr_reg) * 56'(sq_side_reg[SQ_STEPS][127:96]);

    // step divider
    logic        ds_v, ds_ovf;
    logic [32:0] ds_q;
    logic [96:0] ds_side;

    apu_div #(.NW(57), .DW(33), .QW(33), .SW(97)) u_div_step (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p7v_reg),
        .num(57'(prod_p7_reg) + 57'({den_p7_reg, 7'd0})), .den({den_p7_reg, 8'd0}),
        .side_in(side_p7_reg),
        .out_valid(ds_v), .quo(ds_q), .ovf(ds_ovf), .side_out(ds_side)
    );

    // weight update and saturation
    logic [32:0]        step;
    logic signed [34:0] wsx, stx, wdiff;
    logic [31:0]        wnew;
    logic [95:0]        result_next;
    logic               push;

    assign step  = ds_ovf ? '1 : ds_q;
    assign wsx   = $signed({{3{ds_side[31]}}, ds_side[31:0]});
    assign stx   = $signed({2'b00, step});
    assign wdiff = ds_side[96] ? (wsx + stx) : (wsx - stx);
    assign wnew  = (wdiff[34:31] == 4'b0000 || wdiff[34:31] == 4'b1111) ? wdiff[31:0]
                 : (wdiff[34] ? apu_pkg::S32_MIN : apu_pkg::S32_MAX);
    assign result_next = {ds_side[95:64], ds_side[63:32], wnew};
    assign push = en & ds_v;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0v_reg    <= 1'b0;
            p1v_reg    <= 1'b0;
            p2v_reg    <= 1'b0;
            p3v_reg    <= 1'b0;
            p4v_reg    <= 1'b0;
            sq_vld_reg <= '0;
            p7v_reg    <= 1'b0;
        end else if (en) begin
            p0v_reg    <= s_tvalid;
            p1v_reg    <= dt_v;
            p2v_reg    <= p1v_reg;
            p3v_reg    <= p2v_reg;
            p4v_reg    <= p3v_reg;
            sq_vld_reg <= {sq_vld_reg[SQ_STEPS-1:0], dm_v & dv_v};
            p7v_reg    <= sq_vld_reg[SQ_STEPS];
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (en) begin
            numt_p0_reg <= numt_next;
            bs_p0_reg   <= bs_eff;
            side_p0_reg <= {g_in[31], s_tdata[95:0]};

            pa_p1_reg   <= pa_next;
            pb_p1_reg   <= pb_next;
            sqp_p1_reg  <= sqp_next;
            tneg_p1_reg <= dt_side[96];
            w_p1_reg    <= dt_side[31:0];
            v_p1_reg    <= dt_side[95:64];

            acc_p2_reg  <= acc_next;
            sq_p2_reg   <= sq_next;
            w_p2_reg    <= w_p1_reg;
            v_p2_reg    <= v_p1_reg;

            mnew_p3_reg <= mnew_next;
            pv1_p3_reg  <= pv1_next;
            pv2_p3_reg  <= pv2_next;
            w_p3_reg    <= w_p2_reg;

            mnew_p4_reg <= mnew_p3_reg;
            mmag_p4_reg <= mmag_next;
            vnew_p4_reg <= vnew_next;
            w_p4_reg    <= w_p3_reg;

            sq_rad_reg[0]  <= {vhat, 16'd0};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_side_reg[0] <= {mhat_neg, mhat, dv_side, dm_side[63:32], dm_side[31:0]};
            for (int k = 0; k < SQ_STEPS; k++) begin
                sq_rad_reg[k+1]  <= {sq_rad_reg[k][45:0], 2'b00};
                sq_rem_reg[k+1]  <= sq_ge[k] ? 26'(sq_trem[k] - sq_try[k]) : 26'(sq_trem[k]);
                sq_root_reg[k+1] <= {sq_root_reg[k][22:0], sq_ge[k]};
                sq_side_reg[k+1] <= sq_side_reg[k];
            end

            den_p7_reg  <= den_next;
            prod_p7_reg <= prod_next;
            side_p7_reg <= {sq_side_reg[SQ_STEPS][128], sq_side_reg[SQ_STEPS][95:0]};
        end
    end

    // output register with skid entry
    logic [95:0] out_data_reg, skid_data_reg;
    logic        out_vld_reg, skid_vld_reg;

    assign en       = ~skid_vld_reg;
    assign s_tready = ~skid_vld_reg;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            priority if (skid_vld_reg) begin
                if (m_tready) skid_vld_reg <= 1'b0;
            end else if (push) begin
                if (out_vld_reg && !m_tready) skid_vld_reg <= 1'b1;
                else out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        priority if (skid_vld_reg) begin
            if (m_tready) out_data_reg <= skid_data_reg;
        end else if (push) begin
            if (out_vld_reg && !m_tready) skid_data_reg <= result_next;
            else out_data_reg <= result_next;
        end
    end

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry held without a pending output");

    a_drain_no_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !skid_vld_reg) |=> !skid_vld_reg)
        else $error("skid filled while output drained");

    a_mhat_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (sq_vld_reg[0] && sq_side_reg[0][128]) |-> (sq_side_reg[0][127:96] != 32'd0))
        else $error("negative corrected moment with zero magnitude");

endmodule
`default_nettype wire
